[design/agms_pkg.sv]
// shared types and constants of the adjacency matrix graph store
package agms_pkg;

    localparam int CMD_W          = 3;
    localparam int VTX_W          = 4;
    localparam int WEIGHT_W       = 16;
    localparam int TOTAL_W        = 9;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 5;
    localparam int LIST_LIMIT     = 16;
    localparam int EDGE_TOTAL_MAX = 511;

    localparam logic [CFG_DATA_W-1:0] VCOUNT_RESET = 5'd16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTED     = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_TEST   = 3'd2,
        CMD_LIST   = 3'd3,
        CMD_COUNT  = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WR_A,
        ST_WR_B,
        ST_TEST,
        ST_SCAN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic               status;
        logic               adjacent;
        logic [VTX_W-1:0]   neighbour;
        logic               neighbour_valid;
        logic [TOTAL_W-1:0] edge_total;
        logic               last;
    } t_result;

endpackage

[design/agms_in_if.sv]
// command channel: valid/ready handshake with one command item
interface agms_in_if;
    import agms_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [CMD_W-1:0]           cmd;
    logic [VTX_W-1:0]           src;
    logic [VTX_W-1:0]           dest;
    logic signed [WEIGHT_W-1:0] weight;

    modport source (output valid, cmd, src, dest, weight, input ready);
    modport sink   (input valid, cmd, src, dest, weight, output ready);
endinterface

[design/agms_out_if.sv]
// result channel: valid/ready handshake with one result item
interface agms_out_if;
    import agms_pkg::*;

    logic               valid;
    logic               ready;
    logic               status;
    logic               adjacent;
    logic [VTX_W-1:0]   neighbour;
    logic               neighbour_valid;
    logic [TOTAL_W-1:0] edge_total;
    logic               last;

    modport source (output valid, status, adjacent, neighbour, neighbour_valid, edge_total,
                     last, input ready);
    modport sink   (input valid, status, adjacent, neighbour, neighbour_valid, edge_total,
                     last, output ready);
endinterface

[design/adjacency_matrix_graph_store.sv]
// adjacency matrix graph store: top level with weight memory and command sequencer
//
// Holds a MAX_VERTICES x MAX_VERTICES matrix of signed 16-bit edge weights in one
// synchronous memory (one write and one read port, read data registered) plus a
// running count of nonzero entries. After reset the block sweeps the memory to zero,
// one entry per cycle, over all 2^(2*ceil(log2(MAX_VERTICES))) entries (256 at the default);
// no command item is taken during that sweep, configuration writes are. Commands are
// processed one at a time by a small sequencer: an item is taken in the idle state,
// and its result goes through a one-deep output register, so the next item can be
// taken while a result still waits. Per item: error, edge count and unknown codes go
// straight to the result; an adjacency test reads the entry first; add/remove read
// and then write the entry, and when undirected and not a self loop read and write its
// transpose as well; a neighbour listing reads one column after another; the result
// side can stall each of them. Undirected writes go to both the entry and its
// transpose; the edge count is then halved with floor and saturates at 511.
module adjacency_matrix_graph_store #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [agms_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [agms_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    agms_in_if.sink                             i_cmd,
    agms_out_if.source                          o_res
);
    import agms_pkg::*;

    // index and counter widths
    localparam int IW    = $clog2(MAX_VERTICES);
    localparam int AW    = 2 * IW;
    localparam int DEPTH = 1 << AW;
    localparam int XW    = (IW > VTX_W) ? IW : VTX_W;
    localparam int NW    = ($clog2(MAX_VERTICES + 1) > CFG_DATA_W) ?
                           $clog2(MAX_VERTICES + 1) : CFG_DATA_W;
    localparam int CNTW  = $clog2(MAX_VERTICES * MAX_VERTICES + 1);
    localparam int TW    = (CNTW > TOTAL_W) ? CNTW : TOTAL_W;
    localparam int FW    = $clog2(LIST_LIMIT + 1);

    // weight memory
    logic [WEIGHT_W-1:0] mem [DEPTH];
    logic [WEIGHT_W-1:0] r_rd_data;

    // control and datapath registers
    t_state              r_state, n_state;
    logic [AW-1:0]       r_clr, n_clr;
    logic [IW-1:0]       r_row, n_row;
    logic [IW-1:0]       r_col, n_col;
    logic [WEIGHT_W-1:0] r_val, n_val;
    logic                r_mirror, n_mirror;
    logic [FW-1:0]       r_found, n_found;
    t_result             r_pend, n_pend;
    logic [CNTW-1:0]     r_cnt, n_cnt;
    t_result             r_out;
    logic                r_out_valid;
    logic [CFG_DATA_W-1:0] r_vcount;
    logic                r_dir;

    // memory port controls
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [WEIGHT_W-1:0] mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;

    // output register load
    logic                out_load;
    t_result             out_data;
    logic                can_load;

    // decoded command fields
    logic                accept;
    logic [NW-1:0]       n_act;
    logic [XW-1:0]       src_x, dest_x, col_x;
    logic [IW-1:0]       in_row, in_col;
    logic                src_bad, dest_bad;
    logic                was_nz, now_nz;
    logic                hit, last_col;
    logic [CNTW-1:0]     cnt_half;
    logic [TW-1:0]       total_x;
    logic [TOTAL_W-1:0]  total;

    // vertices in use: vertex_count limited to the matrix size
    assign n_act  = (NW'(r_vcount) < NW'(MAX_VERTICES)) ? NW'(r_vcount) : NW'(MAX_VERTICES);
    assign src_x  = XW'(i_cmd.src);
    assign dest_x = XW'(i_cmd.dest);
    assign in_row = src_x[IW-1:0];
    assign in_col = dest_x[IW-1:0];
    assign src_bad  = NW'(i_cmd.src) >= n_act;
    assign dest_bad = NW'(i_cmd.dest) >= n_act;

    assign accept   = i_cmd.valid && i_cmd.ready;
    assign can_load = !r_out_valid || o_res.ready;
    assign i_cmd.ready = (r_state == ST_IDLE);

    // read-modify-write bookkeeping for the nonzero count
    assign was_nz = r_rd_data != '0;
    assign now_nz = r_val != '0;

    // listing scan
    assign hit      = r_rd_data != '0;
    assign last_col = (NW'(r_col) + NW'(1)) == n_act;
    assign col_x    = XW'(r_col);

    // edge count, halved when undirected, saturated to the field
    assign cnt_half = r_dir ? r_cnt : (r_cnt >> 1);
    assign total_x  = TW'(cnt_half);
    assign total    = (total_x > TW'(EDGE_TOTAL_MAX)) ? TOTAL_W'(EDGE_TOTAL_MAX)
                                                     : total_x[TOTAL_W-1:0];

    // sequencer: next state, memory port and result
    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_row     = r_row;
        n_col     = r_col;
        n_val     = r_val;
        n_mirror  = r_mirror;
        n_found   = r_found;
        n_pend    = r_pend;
        n_cnt     = r_cnt;
        mem_we    = 1'b0;
        mem_waddr = {r_row, r_col};
        mem_wdata = r_val;
        mem_re    = 1'b0;
        mem_raddr = {r_row, r_col};
        out_load  = 1'b0;
        out_data  = r_pend;

        case (r_state)
            ST_CLEAR: begin
                // zero sweep after reset
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                n_clr     = r_clr + AW'(1);
                if (r_clr == {AW{1'b1}}) begin
                    n_state = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (accept) begin
                    n_row    = in_row;
                    n_col    = in_col;
                    n_val    = (t_cmd'(i_cmd.cmd) == CMD_ADD) ? i_cmd.weight : '0;
                    n_mirror = !r_dir && (i_cmd.src != i_cmd.dest);
                    n_pend   = '0;
                    n_pend.last = 1'b1;
                    case (t_cmd'(i_cmd.cmd))
                        CMD_ADD, CMD_REMOVE: begin
                            if (src_bad || dest_bad) begin
                                n_pend.status = 1'b1;
                                n_state = ST_EMIT;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = {in_row, in_col};
                                n_state   = ST_WR_A;
                            end
                        end
                        CMD_TEST: begin
                            if (src_bad || dest_bad) begin
                                n_pend.status = 1'b1;
                                n_state = ST_EMIT;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = {in_row, in_col};
                                n_state   = ST_TEST;
                            end
                        end
                        CMD_LIST: begin
                            if (src_bad) begin
                                n_pend.status = 1'b1;
                                n_state = ST_EMIT;
                            end else begin
                                n_col     = '0;
                                n_found   = '0;
                                mem_re    = 1'b1;
                                mem_raddr = {in_row, {IW{1'b0}}};
                                n_state   = ST_SCAN;
                            end
                        end
                        CMD_COUNT: begin
                            n_pend.edge_total = total;
                            n_state = ST_EMIT;
                        end
                        default: begin
                            // unknown code: plain ok result, no change
                            n_state = ST_EMIT;
                        end
                    endcase
                end
            end

            ST_WR_A: begin
                // write the entry, read its transpose when mirrored
                mem_we    = 1'b1;
                mem_waddr = {r_row, r_col};
                if (was_nz && !now_nz) begin
                    n_cnt = r_cnt - CNTW'(1);
                end else if (!was_nz && now_nz) begin
                    n_cnt = r_cnt + CNTW'(1);
                end
                if (r_mirror) begin
                    mem_re    = 1'b1;
                    mem_raddr = {r_col, r_row};
                    n_state   = ST_WR_B;
                end else begin
                    n_state = ST_EMIT;
                end
            end

            ST_WR_B: begin
                mem_we    = 1'b1;
                mem_waddr = {r_col, r_row};
                if (was_nz && !now_nz) begin
                    n_cnt = r_cnt - CNTW'(1);
                end else if (!was_nz && now_nz) begin
                    n_cnt = r_cnt + CNTW'(1);
                end
                n_state = ST_EMIT;
            end

            ST_TEST: begin
                n_pend.adjacent = was_nz;
                n_state = ST_EMIT;
            end

            ST_SCAN: begin
                // r_pend holds the latest neighbour found; it goes out once the
                // next one turns up, or as the final item at the end of the scan
                if (hit) begin
                    if (r_found == '0 || can_load) begin
                        out_load = r_found != '0;
                        n_pend   = '0;
                        n_pend.neighbour       = col_x[VTX_W-1:0];
                        n_pend.neighbour_valid = 1'b1;
                        n_found  = r_found + FW'(1);
                        if ((r_found + FW'(1)) == FW'(LIST_LIMIT) || last_col) begin
                            n_pend.last = 1'b1;
                            n_state     = ST_EMIT;
                        end else begin
                            n_col     = r_col + IW'(1);
                            mem_re    = 1'b1;
                            mem_raddr = {r_row, r_col + IW'(1)};
                        end
                    end
                end else if (last_col) begin
                    if (r_found == '0) begin
                        n_pend = '0;
                    end
                    n_pend.last = 1'b1;
                    n_state     = ST_EMIT;
                end else begin
                    n_col     = r_col + IW'(1);
                    mem_re    = 1'b1;
                    mem_raddr = {r_row, r_col + IW'(1)};
                end
            end

            ST_EMIT: begin
                if (can_load) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_cnt       <= '0;
            r_found     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_clr   <= n_clr;
            r_cnt   <= n_cnt;
            r_found <= n_found;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_row    <= n_row;
        r_col    <= n_col;
        r_val    <= n_val;
        r_mirror <= n_mirror;
        r_pend   <= n_pend;
        if (out_load) begin
            r_out <= out_data;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= VCOUNT_RESET;
            r_dir    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_VERTEX_COUNT: r_vcount <= i_cfg_data;
                CFG_DIRECTED:     r_dir    <= i_cfg_data[0];
                default: begin
                    r_dir <= r_dir;
                end
            endcase
        end
    end

    // weight memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_raddr];
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.status          = r_out.status;
    assign o_res.adjacent        = r_out.adjacent;
    assign o_res.neighbour       = r_out.neighbour;
    assign o_res.neighbour_valid = r_out.neighbour_valid;
    assign o_res.edge_total      = r_out.edge_total;
    assign o_res.last            = r_out.last;

endmodule

[tb/agms_graph_checker.sv]
// result checker for the graph store: tracks the weight matrix from accepted commands
module agms_graph_checker
    import agms_pkg::*;
#(
    parameter int MAX_VERTICES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    agms_in_if                    i_cmd_mon,
    agms_out_if                   i_res_mon,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    logic [WEIGHT_W-1:0]   weight_store [MAX_VERTICES*MAX_VERTICES];
    int unsigned           nonzero_count;
    logic [CFG_DATA_W-1:0] vertex_count;
    logic                  directed;
    t_result               awaited_results [$];
    int                    fail_count;

    function automatic t_result make_result(input logic status, input logic adjacent,
                                            input logic [VTX_W-1:0] neighbour,
                                            input logic neighbour_valid,
                                            input logic [TOTAL_W-1:0] edge_total,
                                            input logic last);
        t_result r;
        r.status          = status;
        r.adjacent        = adjacent;
        r.neighbour       = neighbour;
        r.neighbour_valid = neighbour_valid;
        r.edge_total      = edge_total;
        r.last            = last;
        return r;
    endfunction

    // append one predicted result item at the tail
    function automatic void queue_result(input t_result r);
        awaited_results.insert(awaited_results.size(), r);
    endfunction

    function automatic string describe(input t_result r);
        return $sformatf({"status=%0d adjacent=%0d neighbour=%0d neighbour_valid=%0d",
                          " total=%0d last=%0d"},
                         r.status, r.adjacent, r.neighbour, r.neighbour_valid, r.edge_total,
                         r.last);
    endfunction

    task automatic store_weight(input int row, input int col, input logic [WEIGHT_W-1:0] w);
        int idx;
        idx = row * MAX_VERTICES + col;
        if (weight_store[idx] != '0 && w == '0) begin
            nonzero_count--;
        end else if (weight_store[idx] == '0 && w != '0) begin
            nonzero_count++;
        end
        weight_store[idx] = w;
    endtask

    task automatic predict_graph_response(input logic [CMD_W-1:0] cmd,
                                          input logic [VTX_W-1:0] src,
                                          input logic [VTX_W-1:0] dest,
                                          input logic [WEIGHT_W-1:0] w);
        int                  active;
        int                  found;
        int unsigned         total;
        logic [WEIGHT_W-1:0] value;
        bit                  bad_index;
        active = (int'(vertex_count) < MAX_VERTICES) ? int'(vertex_count) : MAX_VERTICES;
        bad_index = ((cmd == CMD_ADD || cmd == CMD_REMOVE || cmd == CMD_TEST) &&
                     (int'(src) >= active || int'(dest) >= active)) ||
                    (cmd == CMD_LIST && int'(src) >= active);
        if (bad_index) begin
            queue_result(make_result(STATUS_RANGE, 1'b0, '0, 1'b0, '0, 1'b1));
        end else begin
            case (cmd)
                CMD_ADD, CMD_REMOVE: begin
                    value = (cmd == CMD_ADD) ? w : '0;
                    store_weight(int'(src), int'(dest), value);
                    if (!directed && src != dest) begin
                        store_weight(int'(dest), int'(src), value);
                    end
                    queue_result(make_result(STATUS_OK, 1'b0, '0, 1'b0, '0, 1'b1));
                end
                CMD_TEST: begin
                    queue_result(make_result(STATUS_OK,
                        weight_store[int'(src) * MAX_VERTICES + int'(dest)] != '0,
                        '0, 1'b0, '0, 1'b1));
                end
                CMD_LIST: begin
                    found = 0;
                    for (int col = 0; col < active && found < LIST_LIMIT; col++) begin
                        if (weight_store[int'(src) * MAX_VERTICES + col] != '0) begin
                            queue_result(make_result(STATUS_OK, 1'b0,
                                VTX_W'(col), 1'b1, '0, 1'b0));
                            found++;
                        end
                    end
                    if (found == 0) begin
                        queue_result(make_result(STATUS_OK, 1'b0, '0, 1'b0, '0, 1'b1));
                    end else begin
                        awaited_results[$].last = 1'b1;
                    end
                end
                CMD_COUNT: begin
                    total = directed ? nonzero_count : (nonzero_count >> 1);
                    if (total > EDGE_TOTAL_MAX) begin
                        total = EDGE_TOTAL_MAX;
                    end
                    queue_result(make_result(STATUS_OK, 1'b0, '0, 1'b0,
                                             TOTAL_W'(total), 1'b1));
                end
                default: begin
                    queue_result(make_result(STATUS_OK, 1'b0, '0, 1'b0, '0, 1'b1));
                end
            endcase
        end
    endtask

    always @(posedge i_clk) begin
        t_result seen;
        t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_VERTICES * MAX_VERTICES; i++) begin
                weight_store[i] = '0;
            end
            nonzero_count = 0;
            vertex_count  = VCOUNT_RESET;
            directed      = 1'b0;
            fail_count    = 0;
            awaited_results.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_VERTEX_COUNT) begin
                    vertex_count = i_cfg_data;
                end else if (i_cfg_idx == CFG_DIRECTED) begin
                    directed = i_cfg_data[0];
                end
            end
            if (i_res_mon.valid && i_res_mon.ready) begin
                seen = make_result(i_res_mon.status, i_res_mon.adjacent, i_res_mon.neighbour,
                                   i_res_mon.neighbour_valid, i_res_mon.edge_total,
                                   i_res_mon.last);
                if (awaited_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, got %s", $time,
                             describe(seen));
                end else begin
                    want = awaited_results.pop_front();
                    if (seen !== want) begin
                        fail_count++;
                        $display("%0t: result mismatch, expected %s, got %s", $time,
                                 describe(want), describe(seen));
                    end
                end
            end
            if (i_cmd_mon.valid && i_cmd_mon.ready) begin
                predict_graph_response(i_cmd_mon.cmd, i_cmd_mon.src, i_cmd_mon.dest,
                                       i_cmd_mon.weight);
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= awaited_results.size();
    end

endmodule

[tb/adjacency_matrix_graph_store_tb.sv]
// testbench top for the adjacency matrix graph store: stimulus, idling and verdict
module adjacency_matrix_graph_store_tb;
    import agms_pkg::*;

    localparam int VERTICES      = 16;
    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 7;
    // long receiver hold-off, enough to back the block up into its command side
    localparam int STALL_CYCLES  = 200;
    // quiet time after the last result before a register write or the verdict
    localparam int SETTLE_CYCLES = 20;
    localparam int RUN_LIMIT     = 10_000_000;

    // command codes the block answers with a plain ok result
    localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    agms_in_if  cmd_bus ();
    agms_out_if res_bus ();

    int fail_count;
    int pending;
    int send_idle_pct;
    int recv_idle_pct;
    int active_vertices;
    int items_sent;
    bit stall_req;
    bit stall_ack;
    int stall_left;

    adjacency_matrix_graph_store #(
        .MAX_VERTICES (VERTICES)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_cmd      (cmd_bus),
        .o_res      (res_bus)
    );

    agms_graph_checker #(
        .MAX_VERTICES (VERTICES)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_cmd_mon    (cmd_bus),
        .i_res_mon    (res_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // hard stop in case the block hangs or drops results
    initial begin
        #(RUN_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    // result side: random back-pressure, plus one long hold-off when the
    // stimulus flips stall_req; the hold is counted down here
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
            stall_left    <= 0;
            stall_ack     <= 1'b0;
        end else if (stall_left != 0) begin
            res_bus.ready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (stall_req != stall_ack) begin
            stall_ack     <= stall_req;
            stall_left    <= STALL_CYCLES;
            res_bus.ready <= 1'b0;
        end else begin
            res_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // offer one command item, with random gaps before it; valid is left high
    // on return so back-to-back items never drop it within one step
    task automatic issue(input logic [CMD_W-1:0] op, input logic [VTX_W-1:0] src,
                         input logic [VTX_W-1:0] dest, input logic [WEIGHT_W-1:0] w);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_bus.valid  <= 1'b1;
        cmd_bus.cmd    <= op;
        cmd_bus.src    <= src;
        cmd_bus.dest   <= dest;
        cmd_bus.weight <= w;
        @(posedge i_clk);
        while (!cmd_bus.ready) begin
            @(posedge i_clk);
        end
        items_sent++;
    endtask

    // stop offering and wait until every predicted result has been taken;
    // pending is registered in the checker, hence the first wait
    task automatic settle();
        cmd_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write both registers one after the other, meant only for while the block is idle; the task does not enforce it
    task automatic configure(input logic [CFG_DATA_W-1:0] vcount, input logic dir);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_VERTEX_COUNT;
        cfg_data <= vcount;
        @(posedge i_clk);
        cfg_idx  <= CFG_DIRECTED;
        cfg_data <= {{(CFG_DATA_W-1){1'b0}}, dir};
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        active_vertices = (int'(vcount) < VERTICES) ? int'(vcount) : VERTICES;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct <= send_pct;
        recv_idle_pct <= recv_pct;
    endtask

    // mostly in-range vertices, sometimes anything the field holds
    function automatic logic [VTX_W-1:0] pick_vertex();
        if (active_vertices > 0 && $urandom_range(99) < 85) begin
            return VTX_W'($urandom_range(active_vertices - 1, 0));
        end
        return VTX_W'($urandom_range(VERTICES - 1, 0));
    endfunction

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(9))
            0:       return '0;
            1:       return 16'h8000;   // most negative
            2:       return 16'h7fff;   // most positive
            default: return WEIGHT_W'($urandom);
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] CMD_CMD_RSVD_PICK();
        return CMD_W'($urandom_range(CMD_RSVD_HI, CMD_RSVD_LO));
    endfunction

    function automatic logic [CMD_W-1:0] pick_command();
        int roll;
        roll = $urandom_range(99);
        if (roll < 35) begin
            return CMD_ADD;
        end else if (roll < 45) begin
            return CMD_REMOVE;
        end else if (roll < 65) begin
            return CMD_TEST;
        end else if (roll < 80) begin
            return CMD_LIST;
        end else if (roll < 93) begin
            return CMD_COUNT;
        end
        return CMD_CMD_RSVD_PICK();
    endfunction

    // random traffic built from short well-formed sequences: single commands,
    // full-row fills followed by a listing, add/test/remove probes and list/count pairs
    task automatic random_phase(input int quota, input bit hold_midway, input bit pause_midway);
        int               first;
        int               roll;
        int               row;
        bit               held;
        bit               paused;
        logic [VTX_W-1:0] a;
        logic [VTX_W-1:0] b;
        first  = items_sent;
        held   = 1'b0;
        paused = 1'b0;
        while (items_sent - first < quota) begin
            // long result hold-off while commands keep coming
            if (hold_midway && !held && items_sent - first >= quota / 3) begin
                stall_req <= ~stall_req;
                held = 1'b1;
            end
            // sender pause until the block has delivered everything
            if (pause_midway && !paused && items_sent - first >= quota / 2) begin
                settle();
                paused = 1'b1;
            end
            roll = $urandom_range(99);
            if (roll < 45) begin
                issue(pick_command(), pick_vertex(), pick_vertex(), pick_weight());
            end else if (roll < 55) begin
                // fill a whole row so the listing runs to its longest
                row = $urandom_range(active_vertices - 1, 0);
                for (int col = 0; col < active_vertices; col++) begin
                    issue(CMD_ADD, VTX_W'(row), VTX_W'(col),
                          WEIGHT_W'($urandom_range(16'hffff, 1)));
                end
                issue(CMD_LIST, VTX_W'(row), pick_vertex(), pick_weight());
            end else if (roll < 85) begin
                a = pick_vertex();
                b = pick_vertex();
                issue(CMD_ADD, a, b, pick_weight());
                issue(CMD_TEST, a, b, pick_weight());
                issue(CMD_TEST, b, a, pick_weight());
                issue(CMD_REMOVE, a, b, pick_weight());
                issue(CMD_TEST, a, b, pick_weight());
            end else begin
                issue(CMD_LIST, pick_vertex(), pick_vertex(), pick_weight());
                issue(CMD_COUNT, pick_vertex(), pick_vertex(), pick_weight());
            end
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = CFG_VERTEX_COUNT;
        cfg_data        = '0;
        cmd_bus.valid   = 1'b0;
        cmd_bus.cmd     = CMD_ADD;
        cmd_bus.src     = '0;
        cmd_bus.dest    = '0;
        cmd_bus.weight  = '0;
        res_bus.ready   = 1'b0;
        send_idle_pct   = 35;
        recv_idle_pct   = 63;
        active_vertices = VERTICES;
        items_sent      = 0;
        stall_req       = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // undirected, full size; the block may still be sweeping its memory
        configure(5'd16, 1'b0);
        issue(CMD_ADD, 4'd0, 4'd15, 16'h7fff);
        issue(CMD_ADD, 4'd15, 4'd15, 16'h8000);     // self loop, single entry
        issue(CMD_ADD, 4'd3, 4'd7, 16'hffff);
        issue(CMD_ADD, 4'd7, 4'd3, 16'h0001);       // overwrite through the mirror
        issue(CMD_TEST, 4'd15, 4'd0, '0);           // mirrored entry
        issue(CMD_TEST, 4'd0, 4'd1, '0);
        issue(CMD_LIST, 4'd15, 4'd0, '0);
        issue(CMD_LIST, 4'd1, 4'd0, '0);            // empty list
        issue(CMD_COUNT, 4'd0, 4'd0, '0);
        issue(CMD_ADD, 4'd3, 4'd7, '0);             // zero weight removes
        issue(CMD_REMOVE, 4'd0, 4'd15, '0);
        issue(CMD_COUNT, 4'd0, 4'd0, '0);           // lone self loop halves to zero
        issue(CMD_RSVD_LO, 4'd9, 4'd2, 16'h1234);
        issue(CMD_RSVD_LO + 3'd1, 4'd15, 4'd15, 16'hffff);
        issue(CMD_RSVD_HI, 4'd0, 4'd0, '0);
        issue(CMD_ADD, 4'd10, 4'd12, 16'h5a5a);

        // directed, shrunk: the 10/12 pair now lies outside but still counts
        settle();
        configure(5'd5, 1'b1);
        issue(CMD_ADD, 4'd2, 4'd4, 16'd100);
        issue(CMD_TEST, 4'd4, 4'd2, '0);
        issue(CMD_ADD, 4'd5, 4'd0, 16'd9);          // source at the limit
        issue(CMD_TEST, 4'd0, 4'd15, '0);           // destination out of range
        issue(CMD_LIST, 4'd9, 4'd0, '0);
        issue(CMD_COUNT, 4'd0, 4'd0, '0);
        issue(CMD_LIST, 4'd2, 4'd0, '0);

        // no vertices at all: everything but the count is out of range
        settle();
        configure(5'd0, 1'b1);
        issue(CMD_ADD, 4'd0, 4'd0, 16'd1);
        issue(CMD_LIST, 4'd0, 4'd0, '0);
        issue(CMD_COUNT, 4'd0, 4'd0, '0);

        // single vertex, undirected self loop
        settle();
        configure(5'd1, 1'b0);
        issue(CMD_ADD, 4'd0, 4'd0, 16'd7);
        issue(CMD_LIST, 4'd0, 4'd0, '0);
        issue(CMD_TEST, 4'd0, 4'd1, '0);

        // count above the limit clamps to full size; hidden entries return
        settle();
        configure(5'd31, 1'b0);
        issue(CMD_LIST, 4'd10, 4'd0, '0);
        issue(CMD_COUNT, 4'd0, 4'd0, '0);

        // random traffic, first with the sender lightly and the receiver
        // heavily idle, plus one long result hold-off
        settle();
        configure(5'd16, 1'b0);
        random_phase(40, 1'b1, 1'b0);

        // roles swapped, directed, random size, with a full drain midway
        settle();
        set_idling(63, 35);
        configure(5'($urandom_range(15, 1)), 1'b1);
        random_phase(40, 1'b0, 1'b1);

        // no idling on either side
        settle();
        set_idling(0, 0);
        configure(5'd16, 1'b1);
        random_phase(40, 1'b0, 1'b0);

        settle();
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
